[rtl/bapw_pkg.sv]
// bapw_pkg: shared types and constants of the backbone axis point window unit
// holds register indexes, reset values and fixed datapath widths
// no dependencies
package bapw_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIST_MIN      = 3'd0,
    REG_DIST_MAX      = 3'd1,
    REG_RADIUS_ALPHA  = 3'd2,
    REG_RADIUS_310    = 3'd3,
    REG_RADIUS_PI     = 3'd4
  } reg_idx_t;

  localparam int DIST_W   = 16;
  localparam int RADIUS_W = 12;

  localparam logic [DIST_W-1:0]   DIST_MIN_RST     = 16'd922;
  localparam logic [DIST_W-1:0]   DIST_MAX_RST     = 16'd1024;
  localparam logic [RADIUS_W-1:0] RADIUS_ALPHA_RST = 12'd589;
  localparam logic [RADIUS_W-1:0] RADIUS_310_RST   = 12'd486;
  localparam logic [RADIUS_W-1:0] RADIUS_PI_RST    = 12'd717;

  // helix kinds
  localparam logic [1:0] HK_THREE_TEN = 2'd1;
  localparam logic [1:0] HK_PI        = 2'd2;

  // segment kind
  localparam logic KIND_HELIX = 1'b0;

  // shared multiplier
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;

  // datapath widths, bounded by the distance band check
  localparam int W_W     = 18;  // bend vector component, signed
  localparam int WABS_W  = 17;
  localparam int DSQ_W   = 34;  // sum of three 16 bit squares
  localparam int S_W     = 36;  // squared bend length
  localparam int S_HALF  = 18;
  localparam int A_W     = 29;  // radius times component
  localparam int LIM_W   = 60;  // four times a squared
  localparam int MAG_W   = 12;  // spoke magnitude
  localparam int BIT_W   = 4;
  localparam int T_W     = 13;  // odd trial value
  localparam int T2_W    = 26;
  localparam int PLO_W   = 44;
  localparam int TOT_W   = 62;

  localparam logic [1:0] LAST_COMP = 2'd2;
  localparam logic [BIT_W-1:0] TOP_BIT = 4'd11;

endpackage

[rtl/backbone_axis_point_window_unit.sv]
// backbone_axis_point_window_unit: top level, three residue window with sequenced arithmetic
// depends on bapw_pkg and bapw_mul
//
// usage
//   input channel (in_valid / in_stall): one alpha-carbon residue per transfer with segment
//   marks, presence flag, position and helix kind. output channel (out_valid / out_stall):
//   one axis point per transfer, point_valid low and zero coordinates for end residues,
//   failed checks and zero-length spokes. each input gives zero, one or two results. cfg_we
//   with cfg_index and cfg_data writes one register; user writes only while idle, unenforced.
// timing
//   one residue at a time; in_stall stays high until its results are in the output register.
//   an interior helix residue runs the 12 step spoke search per component, each step going
//   through S_T, S_TL, S_TH and S_TC with three passes through the one 32x32 multiplier.
//   an interior strand residue takes the 1-2-1 mean instead; output stalls hold the sequencer.
// reset
//   rst empties the window and the output register and loads the register defaults.
// stall
//   a result waits in the output register while out_stall is high; the sequencer holds
//   before loading the next result, so nothing is lost or repeated.
module backbone_axis_point_window_unit #(
  parameter int COORD_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [bapw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bapw_pkg::CFG_DATA_W-1:0]     cfg_data,
  // residue input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                kind,
  input  logic                                seg_first,
  input  logic                                seg_last,
  input  logic                                present,
  input  logic signed [COORD_BITS-1:0]        pos_x,
  input  logic signed [COORD_BITS-1:0]        pos_y,
  input  logic signed [COORD_BITS-1:0]        pos_z,
  input  logic [1:0]                          helix_kind,
  // axis point output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                point_valid,
  output logic signed [COORD_BITS-1:0]        axis_x,
  output logic signed [COORD_BITS-1:0]        axis_y,
  output logic signed [COORD_BITS-1:0]        axis_z,
  output logic                                run_last
);

  localparam int CB    = COORD_BITS;
  localparam int DIFF_W = CB + 1;
  localparam int SUM_W  = CB + 3;

  typedef enum logic [4:0] {
    S_IDLE, S_BND0, S_BND1, S_BND2,
    S_DIFF, S_DSQ, S_DACC, S_DCHK,
    S_W, S_WSQ, S_WACC, S_SCHK,
    S_RA, S_AA, S_LIM, S_T, S_TL, S_TH, S_TC, S_SP,
    S_STR, S_RESULT, S_EMIT, S_TAIL
  } state_t;

  state_t st;

  // configuration registers
  logic [bapw_pkg::DIST_W-1:0]   dist_min, dist_max;
  logic [bapw_pkg::RADIUS_W-1:0] radius_alpha, radius_three_ten, radius_pi;

  // window: entry 1 newest held residue, entry 0 the one before
  logic signed [CB-1:0] win_x [2];
  logic signed [CB-1:0] win_y [2];
  logic signed [CB-1:0] win_z [2];
  logic                 win_present [2];
  logic [1:0]           mid_helix_kind;
  logic [1:0]           seg_fill;
  logic [1:0]           fill_eff;

  // current residue
  logic signed [CB-1:0] cur_x, cur_y, cur_z;
  logic                 cur_present, cur_kind, cur_last;
  logic [1:0]           cur_hk;

  // sequencer working registers
  logic                              ok;
  logic                              pair;
  logic [1:0]                        comp;
  logic [bapw_pkg::DIST_W-1:0]       dreg;
  logic [bapw_pkg::DSQ_W-1:0]        acc;
  logic [bapw_pkg::MUL_W-1:0]        minsq, maxsq;
  logic signed [bapw_pkg::W_W-1:0]   w [3];
  logic [bapw_pkg::S_W-1:0]          s;
  logic [bapw_pkg::LIM_W-1:0]        lim;
  logic [bapw_pkg::MAG_W-1:0]        q;
  logic [bapw_pkg::BIT_W-1:0]        bitn;
  logic [bapw_pkg::T2_W-1:0]         t2;
  logic [bapw_pkg::PLO_W-1:0]        plo;
  logic signed [CB-1:0]              res [3];
  logic                              e_pv, e_last, emit_tail;

  // shared multiplier
  logic [bapw_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic [bapw_pkg::PROD_W-1:0] prod;

  bapw_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  function automatic logic signed [CB-1:0] pick(
    input logic [1:0] c,
    input logic signed [CB-1:0] x,
    input logic signed [CB-1:0] y,
    input logic signed [CB-1:0] z
  );
    case (c)
      2'd0:    pick = x;
      2'd1:    pick = y;
      default: pick = z;
    endcase
  endfunction

  // clamp one extra bit back into the coordinate range
  function automatic logic signed [CB-1:0] sat1(input logic signed [CB:0] v);
    if (v[CB] != v[CB-1]) begin
      sat1 = v[CB] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
    end else begin
      sat1 = v[CB-1:0];
    end
  endfunction

  // operands of the current component
  logic signed [CB-1:0] p0c, p1c, p2c;
  assign p0c = pick(comp, win_x[0], win_y[0], win_z[0]);
  assign p1c = pick(comp, win_x[1], win_y[1], win_z[1]);
  assign p2c = pick(comp, cur_x, cur_y, cur_z);

  // neighbour difference, first pair p1-p0, second pair p2-p1
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        absd;
  always_comb begin
    if (pair) begin
      diff = DIFF_W'(p2c) - DIFF_W'(p1c);
    end else begin
      diff = DIFF_W'(p1c) - DIFF_W'(p0c);
    end
    absd = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  end

  // bend vector and strand sum
  logic signed [SUM_W-1:0] wsum, ssum;
  assign wsum = SUM_W'(p0c) + SUM_W'(p2c) - (SUM_W'(p1c) <<< 1);
  assign ssum = SUM_W'(p0c) + (SUM_W'(p1c) <<< 1) + SUM_W'(p2c) + SUM_W'(2);

  logic signed [bapw_pkg::W_W-1:0] wsel;
  logic [bapw_pkg::W_W-1:0]        wneg;
  logic [bapw_pkg::WABS_W-1:0]     wabs;
  assign wsel = w[comp];
  assign wneg = bapw_pkg::W_W'(-wsel);
  assign wabs = wsel[bapw_pkg::W_W-1] ? wneg[bapw_pkg::WABS_W-1:0]
                                      : wsel[bapw_pkg::WABS_W-1:0];

  logic [bapw_pkg::RADIUS_W-1:0] r_sel;
  always_comb begin
    case (mid_helix_kind)
      bapw_pkg::HK_THREE_TEN: r_sel = radius_three_ten;
      bapw_pkg::HK_PI:        r_sel = radius_pi;
      default:                r_sel = radius_alpha;
    endcase
  end

  // trial magnitude and its odd double
  logic [bapw_pkg::MAG_W-1:0] qc;
  logic [bapw_pkg::T_W-1:0]   t;
  logic [bapw_pkg::TOT_W-1:0] tot;
  assign qc  = q | (bapw_pkg::MAG_W'(1) << bitn);
  assign t   = {qc, 1'b0} - bapw_pkg::T_W'(1);
  assign tot = bapw_pkg::TOT_W'(plo) + (bapw_pkg::TOT_W'(prod) << bapw_pkg::S_HALF);

  // spoke added to the middle atom
  logic signed [CB:0] spoke_sum;
  assign spoke_sum = wsel[bapw_pkg::W_W-1] ? ((CB+1)'(p1c) - (CB+1)'(q))
                                           : ((CB+1)'(p1c) + (CB+1)'(q));

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st)
      S_BND0: begin
        mul_a = bapw_pkg::MUL_W'(dist_min);
        mul_b = bapw_pkg::MUL_W'(dist_min);
      end
      S_BND1: begin
        mul_a = bapw_pkg::MUL_W'(dist_max);
        mul_b = bapw_pkg::MUL_W'(dist_max);
      end
      S_DSQ: begin
        mul_a = bapw_pkg::MUL_W'(dreg);
        mul_b = bapw_pkg::MUL_W'(dreg);
      end
      S_WSQ: begin
        mul_a = bapw_pkg::MUL_W'(wabs);
        mul_b = bapw_pkg::MUL_W'(wabs);
      end
      S_RA: begin
        mul_a = bapw_pkg::MUL_W'(r_sel);
        mul_b = bapw_pkg::MUL_W'(wabs);
      end
      S_AA: begin
        mul_a = bapw_pkg::MUL_W'(prod[bapw_pkg::A_W-1:0]);
        mul_b = bapw_pkg::MUL_W'(prod[bapw_pkg::A_W-1:0]);
      end
      S_T: begin
        mul_a = bapw_pkg::MUL_W'(t);
        mul_b = bapw_pkg::MUL_W'(t);
      end
      S_TL: begin
        mul_a = bapw_pkg::MUL_W'(prod[bapw_pkg::T2_W-1:0]);
        mul_b = bapw_pkg::MUL_W'(s[bapw_pkg::S_HALF-1:0]);
      end
      S_TH: begin
        mul_a = bapw_pkg::MUL_W'(t2);
        mul_b = bapw_pkg::MUL_W'(s[bapw_pkg::S_W-1:bapw_pkg::S_HALF]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign in_stall = (st != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st               <= S_IDLE;
      out_valid        <= 1'b0;
      seg_fill         <= 2'd0;
      dist_min         <= bapw_pkg::DIST_MIN_RST;
      dist_max         <= bapw_pkg::DIST_MAX_RST;
      radius_alpha     <= bapw_pkg::RADIUS_ALPHA_RST;
      radius_three_ten <= bapw_pkg::RADIUS_310_RST;
      radius_pi        <= bapw_pkg::RADIUS_PI_RST;
      win_present[0]   <= 1'b0;
      win_present[1]   <= 1'b0;
      mid_helix_kind   <= 2'd0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          bapw_pkg::REG_DIST_MIN:     dist_min <= cfg_data;
          bapw_pkg::REG_DIST_MAX:     dist_max <= cfg_data;
          bapw_pkg::REG_RADIUS_ALPHA: radius_alpha <= cfg_data[bapw_pkg::RADIUS_W-1:0];
          bapw_pkg::REG_RADIUS_310:   radius_three_ten <= cfg_data[bapw_pkg::RADIUS_W-1:0];
          bapw_pkg::REG_RADIUS_PI:    radius_pi <= cfg_data[bapw_pkg::RADIUS_W-1:0];
          default: ;
        endcase
      end

      // output transfer frees the register
      if (out_valid && !out_stall && st != S_EMIT) begin
        out_valid <= 1'b0;
      end

      case (st)
        S_IDLE: begin
          if (in_valid) begin
            cur_x       <= pos_x;
            cur_y       <= pos_y;
            cur_z       <= pos_z;
            cur_present <= present;
            cur_kind    <= kind;
            cur_last    <= seg_last;
            cur_hk      <= helix_kind;
            fill_eff    <= seg_first ? 2'd0 : seg_fill;
            ok          <= win_present[0] && win_present[1] && present;
            pair        <= 1'b0;
            comp        <= 2'd0;
            acc         <= '0;
            if (!seg_first && seg_fill == 2'd2) begin
              st <= S_BND0;
            end else if (!seg_first && seg_fill == 2'd1) begin
              // second residue of a segment: the first one is an end residue
              e_pv      <= 1'b0;
              e_last    <= 1'b0;
              emit_tail <= 1'b1;
              st        <= S_EMIT;
            end else begin
              st <= S_TAIL;
            end
          end
        end
        // squared band limits
        S_BND0: st <= S_BND1;
        S_BND1: begin
          minsq <= prod[bapw_pkg::MUL_W-1:0];
          st    <= S_BND2;
        end
        S_BND2: begin
          maxsq <= prod[bapw_pkg::MUL_W-1:0];
          st    <= ok ? S_DIFF : S_RESULT;
        end
        // neighbour distances, one component per pass
        S_DIFF: begin
          if (absd > DIFF_W'(dist_max)) begin
            ok <= 1'b0;
            st <= S_RESULT;
          end else begin
            dreg <= absd[bapw_pkg::DIST_W-1:0];
            st   <= S_DSQ;
          end
        end
        S_DSQ: st <= S_DACC;
        S_DACC: begin
          acc <= acc + prod[bapw_pkg::DSQ_W-1:0];
          if (comp == bapw_pkg::LAST_COMP) begin
            st <= S_DCHK;
          end else begin
            comp <= comp + 2'd1;
            st   <= S_DIFF;
          end
        end
        S_DCHK: begin
          comp <= 2'd0;
          acc  <= '0;
          s    <= '0;
          if (acc < bapw_pkg::DSQ_W'(minsq) || acc > bapw_pkg::DSQ_W'(maxsq)) begin
            ok <= 1'b0;
            st <= S_RESULT;
          end else if (!pair) begin
            pair <= 1'b1;
            st   <= S_DIFF;
          end else if (cur_kind == bapw_pkg::KIND_HELIX) begin
            st <= S_W;
          end else begin
            st <= S_STR;
          end
        end
        // bend vector and its squared length
        S_W: begin
          w[comp] <= wsum[bapw_pkg::W_W-1:0];
          st      <= S_WSQ;
        end
        S_WSQ: st <= S_WACC;
        S_WACC: begin
          s <= s + prod[bapw_pkg::S_W-1:0];
          if (comp == bapw_pkg::LAST_COMP) begin
            st <= S_SCHK;
          end else begin
            comp <= comp + 2'd1;
            st   <= S_W;
          end
        end
        S_SCHK: begin
          comp <= 2'd0;
          if (s == '0) begin
            // zero-length spoke
            ok <= 1'b0;
            st <= S_RESULT;
          end else begin
            st <= S_RA;
          end
        end
        // spoke magnitude: largest q with (2q-1)^2 s <= 4 (r |w|)^2
        S_RA: st <= S_AA;
        S_AA: st <= S_LIM;
        S_LIM: begin
          lim  <= {prod[bapw_pkg::LIM_W-3:0], 2'b00};
          q    <= '0;
          bitn <= bapw_pkg::TOP_BIT;
          st   <= S_T;
        end
        S_T: st <= S_TL;
        S_TL: begin
          t2 <= prod[bapw_pkg::T2_W-1:0];
          st <= S_TH;
        end
        S_TH: begin
          plo <= prod[bapw_pkg::PLO_W-1:0];
          st  <= S_TC;
        end
        S_TC: begin
          if (tot <= bapw_pkg::TOT_W'(lim)) begin
            q <= qc;
          end
          if (bitn == '0) begin
            st <= S_SP;
          end else begin
            bitn <= bitn - bapw_pkg::BIT_W'(1);
            st   <= S_T;
          end
        end
        S_SP: begin
          res[comp] <= sat1(spoke_sum);
          if (comp == bapw_pkg::LAST_COMP) begin
            st <= S_RESULT;
          end else begin
            comp <= comp + 2'd1;
            st   <= S_RA;
          end
        end
        // strand: 1-2-1 mean, quarter rounded half up
        S_STR: begin
          res[comp] <= sat1(ssum[SUM_W-1:2]);
          if (comp == bapw_pkg::LAST_COMP) begin
            st <= S_RESULT;
          end else begin
            comp <= comp + 2'd1;
          end
        end
        S_RESULT: begin
          e_pv      <= ok;
          e_last    <= 1'b0;
          emit_tail <= 1'b1;
          st        <= S_EMIT;
        end
        // load the output register once it is free
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            point_valid <= e_pv;
            axis_x      <= e_pv ? res[0] : '0;
            axis_y      <= e_pv ? res[1] : '0;
            axis_z      <= e_pv ? res[2] : '0;
            run_last    <= e_last;
            st          <= emit_tail ? S_TAIL : S_IDLE;
          end
        end
        // slide the window
        S_TAIL: begin
          win_x[0]       <= win_x[1];
          win_y[0]       <= win_y[1];
          win_z[0]       <= win_z[1];
          win_present[0] <= win_present[1];
          win_x[1]       <= cur_x;
          win_y[1]       <= cur_y;
          win_z[1]       <= cur_z;
          win_present[1] <= cur_present;
          mid_helix_kind <= cur_hk;
          if (cur_last) begin
            seg_fill  <= 2'd0;
            e_pv      <= 1'b0;
            e_last    <= 1'b1;
            emit_tail <= 1'b0;
            st        <= S_EMIT;
          end else begin
            seg_fill <= (fill_eff == 2'd2) ? 2'd2 : fill_eff + 2'd1;
            st       <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/bapw_mul.sv]
// bapw_mul: shared unsigned multiplier with registered product
// depends on bapw_pkg for operand width
module bapw_mul (
  input  logic                         clk,
  input  logic [bapw_pkg::MUL_W-1:0]   a,
  input  logic [bapw_pkg::MUL_W-1:0]   b,
  output logic [bapw_pkg::PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= bapw_pkg::PROD_W'(a) * bapw_pkg::PROD_W'(b);
  end

endmodule

[rtl/bapw_chk.sv]
// bapw_chk: port-level checks of the backbone axis point window unit
// depends on bapw_pkg; bound to backbone_axis_point_window_unit
module bapw_chk #(
  parameter int COORD_BITS = 24
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            cfg_we,
  input logic [bapw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [bapw_pkg::CFG_DATA_W-1:0] cfg_data,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            kind,
  input logic                            seg_first,
  input logic                            seg_last,
  input logic                            present,
  input logic [COORD_BITS-1:0]           pos_x,
  input logic [COORD_BITS-1:0]           pos_y,
  input logic [COORD_BITS-1:0]           pos_z,
  input logic [1:0]                      helix_kind,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            point_valid,
  input logic [COORD_BITS-1:0]           axis_x,
  input logic [COORD_BITS-1:0]           axis_y,
  input logic [COORD_BITS-1:0]           axis_z,
  input logic                            run_last
);

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // a stalled result stays
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  // invalid points carry zero coordinates
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !point_valid |-> axis_x == '0 && axis_y == '0 && axis_z == '0)
    else $error("invalid point with nonzero coordinates");

  // the segment end result is always an end residue
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_last |-> !point_valid)
    else $error("valid point on segment end");

  // a transfer taken in makes the unit busy next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("unit not busy after input transfer");

endmodule

bind backbone_axis_point_window_unit bapw_chk #(.COORD_BITS(COORD_BITS)) u_bapw_chk (.*);
